// ===== sv/video_stream_packet_classifier_unit_assert.svh =====
// Assertion macros shared by the packet classifier RTL.
// Each macro expands to a labeled concurrent assertion, or to nothing
// when NO_ASSERTIONS is defined.
`ifndef VIDEO_STREAM_PACKET_CLASSIFIER_UNIT_ASSERT_SVH
`define VIDEO_STREAM_PACKET_CLASSIFIER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS
// The property must hold at every clock edge outside of reset.
`define VSPC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// The expression must never be true outside of reset.
`define VSPC_ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define VSPC_ASSERT(label, clk, rst_n, prop, msg)
`define VSPC_ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

// ===== sv/vspc_pkg.sv =====
// Package for the packet classifier: codes, match constants and the record
// passed from the byte scanner to the verdict stage. No dependencies.
`default_nettype none

package vspc_pkg;

    localparam int HDR_DEPTH   = 15;
    localparam int HDR_IDX_W   = $clog2(HDR_DEPTH);
    localparam int PREFIX_LEN  = 11;
    localparam int PATH_LEN    = 7;
    localparam int QDEPTH      = 2;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);

    localparam logic [15:0] TAIL_FIRST    = 16'd52;
    localparam logic [15:0] TAIL_LAST     = 16'd55;
    localparam logic [15:0] TCP_MIN_LEN   = 16'd60;
    localparam logic [15:0] ECHO_MIN_LEN  = 16'd14;
    localparam logic [15:0] UDP_MIN_LEN   = 16'd16;
    localparam logic [15:0] POS_MAX       = 16'hFFFF;
    localparam logic [7:0]  MARKER_BYTE   = 8'h1a;
    localparam logic [7:0]  ECHO_TAG      = 8'h01;
    localparam logic [7:0]  UDP_TAG       = 8'h43;
    localparam logic [7:0]  UDP_FLAG      = 8'h80;
    localparam logic [7:0]  UDP_HDR_LEN   = 8'h14;
    localparam logic [2:0]  UDP_HIT_STAGE = 3'd5;

    typedef enum logic [1:0] {
        TRANSPORT_OTHER = 2'd0,
        TRANSPORT_TCP   = 2'd1,
        TRANSPORT_UDP   = 2'd2
    } transport_t;

    typedef enum logic [1:0] {
        VERDICT_UNDECIDED = 2'd0,
        VERDICT_DETECTED  = 2'd1,
        VERDICT_EXCLUDED  = 2'd2
    } verdict_t;

    // One finished packet on its way to the verdict stage.
    typedef struct packed {
        logic [1:0] verdict;     // final verdict unless udp_count is set
        logic       udp_count;   // qualifying UDP packet, verdict set by stage
        logic       stage_clear; // a new flow began in this packet
    } rec_t;

    typedef logic [HDR_DEPTH-1:0][7:0] hdr_t;

    function automatic logic [7:0] prefix_byte(input logic [3:0] idx);
        logic [7:0] val;
        case (idx)
            4'd0:    val = 8'h50;
            4'd1:    val = 8'h53;
            4'd2:    val = 8'h50;
            4'd3:    val = 8'h72;
            4'd4:    val = 8'h6f;
            4'd5:    val = 8'h74;
            4'd6:    val = 8'h6f;
            4'd7:    val = 8'h63;
            4'd8:    val = 8'h6f;
            4'd9:    val = 8'h6c;
            default: val = 8'h00;
        endcase
        return val;
    endfunction

    function automatic logic [7:0] path_byte(input logic [2:0] idx);
        logic [7:0] val;
        case (idx)
            3'd0:    val = 8'h2f;
            3'd1:    val = 8'h76;
            3'd2:    val = 8'h69;
            3'd3:    val = 8'h64;
            3'd4:    val = 8'h65;
            3'd5:    val = 8'h6f;
            default: val = 8'h73;
        endcase
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== sv/vspc_front.sv =====
// Byte scanner: tracks per-packet match state and, on the last byte of a
// packet, pushes a classification record. Depends on vspc_pkg.
`default_nettype none

module vspc_front
    import vspc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_transport,
    input  wire logic [15:0] s_packet_length,
    input  wire logic [7:0]  s_payload_byte,
    input  wire logic        s_last_byte,
    input  wire logic        s_flow_start,
    output logic             push_valid,
    input  wire logic        push_ready,
    output rec_t             push_data
);

    logic [15:0] pos_reg, pos_next;
    hdr_t        hdr_reg, hdr_next;
    logic        prefix_reg, prefix_next;
    logic        tail_reg, tail_next;
    logic [7:0]  prev_reg, prev_next;
    logic        marker_reg, marker_next;
    logic [2:0]  prog_reg, prog_next;
    logic        pmatch_reg, pmatch_next;
    logic        clear_reg, clear_next;

    logic        s_fire;
    logic        in_range;
    logic        tcp_det, udp_qual, udp_pattern;
    logic [15:0] len;
    logic [15:0] word0;
    logic [8:0]  a_ext, b_ext;

    assign s_ready    = push_ready;
    assign s_fire     = s_valid && s_ready;
    assign push_valid = s_valid && s_last_byte;
    assign len        = s_packet_length;

    always_comb begin
        in_range    = pos_reg < len;
        hdr_next    = hdr_reg;
        prefix_next = prefix_reg;
        tail_next   = tail_reg;
        prev_next   = prev_reg;
        marker_next = marker_reg;
        prog_next   = prog_reg;
        pmatch_next = pmatch_reg;
        pos_next    = (pos_reg == POS_MAX) ? pos_reg : pos_reg + 16'd1;
        clear_next  = clear_reg || s_flow_start;

        if (in_range) begin
            if (pos_reg < 16'(HDR_DEPTH)) begin
                hdr_next[pos_reg[HDR_IDX_W-1:0]] = s_payload_byte;
            end
            if (pos_reg < 16'(PREFIX_LEN) && s_payload_byte != prefix_byte(pos_reg[3:0])) begin
                prefix_next = 1'b0;
            end
            if (pos_reg >= TAIL_FIRST && pos_reg <= TAIL_LAST && s_payload_byte != 8'd0) begin
                tail_next = 1'b0;
            end
            // A 0x1a 0x00 pair restarts the path compare after it.
            if (pos_reg != 16'd0 && prev_reg == MARKER_BYTE && s_payload_byte == 8'd0) begin
                marker_next = 1'b1;
                prog_next   = 3'd0;
                pmatch_next = 1'b1;
            end else if (marker_reg && prog_reg < 3'(PATH_LEN)) begin
                if (s_payload_byte != path_byte(prog_reg)) begin
                    pmatch_next = 1'b0;
                end
                prog_next = prog_reg + 3'd1;
            end
            prev_next = s_payload_byte;
        end
    end

    always_comb begin
        word0 = {hdr_next[1], hdr_next[0]};
        a_ext = {1'b0, hdr_next[12]};
        b_ext = {1'b0, hdr_next[13]};

        tcp_det = (len >= TCP_MIN_LEN && prefix_next && tail_next)
               || (len == {8'd0, hdr_next[0]} && hdr_next[4] == ECHO_TAG
                   && len > ECHO_MIN_LEN && marker_next && pmatch_next
                   && prog_next == 3'(PATH_LEN));

        udp_qual = len > 16'd2 && hdr_next[2] == UDP_TAG
                && ((len >= 16'd4 && len - 16'd4 == word0) || len == word0
                    || (len >= 16'd6 && len - 16'd6 == word0));

        udp_pattern = len >= UDP_MIN_LEN && hdr_next[1] == UDP_FLAG
                   && hdr_next[3] == hdr_next[4]
                   && (a_ext == b_ext + 9'd1 || a_ext + 9'd1 == b_ext || a_ext == b_ext)
                   && hdr_next[13] == hdr_next[14]
                   && (len == {8'd0, hdr_next[0]} || hdr_next[0] == UDP_HDR_LEN);

        push_data.stage_clear = clear_next;
        push_data.udp_count   = 1'b0;
        push_data.verdict     = VERDICT_EXCLUDED;
        case (s_transport)
            TRANSPORT_TCP: begin
                push_data.verdict = tcp_det ? VERDICT_DETECTED : VERDICT_EXCLUDED;
            end
            TRANSPORT_UDP: begin
                push_data.udp_count = udp_qual;
                push_data.verdict   = (!udp_qual && udp_pattern) ? VERDICT_DETECTED
                                                                 : VERDICT_EXCLUDED;
            end
            default: begin
                push_data.verdict = VERDICT_EXCLUDED;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg    <= 16'd0;
            prefix_reg <= 1'b1;
            tail_reg   <= 1'b1;
            prev_reg   <= 8'd0;
            marker_reg <= 1'b0;
            prog_reg   <= 3'd0;
            pmatch_reg <= 1'b0;
            clear_reg  <= 1'b0;
        end else if (s_fire) begin
            if (s_last_byte) begin
                pos_reg    <= 16'd0;
                prefix_reg <= 1'b1;
                tail_reg   <= 1'b1;
                prev_reg   <= 8'd0;
                marker_reg <= 1'b0;
                prog_reg   <= 3'd0;
                pmatch_reg <= 1'b0;
                clear_reg  <= 1'b0;
            end else begin
                pos_reg    <= pos_next;
                prefix_reg <= prefix_next;
                tail_reg   <= tail_next;
                prev_reg   <= prev_next;
                marker_reg <= marker_next;
                prog_reg   <= prog_next;
                pmatch_reg <= pmatch_next;
                clear_reg  <= clear_next;
            end
        end
    end

    // Header bytes persist across packets and need no reset.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            hdr_reg <= hdr_next;
        end
    end

`include "video_stream_packet_classifier_unit_assert.svh"

    `VSPC_ASSERT(a_pos_restarts, aclk, aresetn, (s_fire && s_last_byte) |=> (pos_reg == 16'd0 && !clear_reg), "packet state not cleared after last byte")

endmodule

`default_nettype wire

// ===== sv/vspc_queue.sv =====
// Short record queue between the byte scanner and the verdict stage.
// Depends on vspc_pkg.
`default_nettype none

module vspc_queue
    import vspc_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push_valid,
    output logic      push_ready,
    input  wire rec_t push_data,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output rec_t      pop_data
);

    rec_t              mem_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg, count_next;
    logic              push_fire, pop_fire;

    assign push_ready = count_reg != QCNT_W'(QDEPTH);
    assign pop_valid  = count_reg != '0;
    assign push_fire  = push_valid && push_ready;
    assign pop_fire   = pop_valid && pop_ready;
    assign pop_data   = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push_fire && !pop_fire) begin
            count_next = count_reg + QCNT_W'(1);
        end else if (pop_fire && !push_fire) begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push_fire) begin
                wr_ptr_reg <= (wr_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + QPTR_W'(1);
            end
            if (pop_fire) begin
                rd_ptr_reg <= (rd_ptr_reg == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push_fire) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

`include "video_stream_packet_classifier_unit_assert.svh"

    `VSPC_ASSERT_NEVER(a_count_bound, aclk, aresetn, count_reg > QCNT_W'(QDEPTH), "queue count beyond depth")
    `VSPC_ASSERT(a_push_visible, aclk, aresetn, (push_fire && count_reg == '0) |=> pop_valid, "pushed record not visible")

endmodule

`default_nettype wire

// ===== sv/vspc_back.sv =====
// Verdict stage: keeps the per-flow UDP stage counter and holds the
// result register toward the output channel. Depends on vspc_pkg.
`default_nettype none

module vspc_back
    import vspc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        pop_valid,
    output logic             pop_ready,
    input  wire rec_t        pop_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_verdict
);

    logic [2:0] stage_reg, stage_next;
    logic [2:0] stage_base;
    logic       valid_reg;
    logic [1:0] verdict_reg, verdict_next;
    logic       pop_fire;

    assign pop_ready = !valid_reg || m_ready;
    assign pop_fire  = pop_valid && pop_ready;
    assign m_valid   = valid_reg;
    assign m_verdict = verdict_reg;

    always_comb begin
        stage_base   = pop_data.stage_clear ? 3'd0 : stage_reg;
        stage_next   = stage_base;
        verdict_next = pop_data.verdict;
        if (pop_data.udp_count) begin
            stage_next   = stage_base + 3'd1;
            verdict_next = (stage_next == UDP_HIT_STAGE) ? VERDICT_DETECTED
                                                         : VERDICT_UNDECIDED;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg <= 3'd0;
            valid_reg <= 1'b0;
        end else begin
            if (pop_fire) begin
                stage_reg <= stage_next;
                valid_reg <= 1'b1;
            end else if (m_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop_fire) begin
            verdict_reg <= verdict_next;
        end
    end

`include "video_stream_packet_classifier_unit_assert.svh"

    `VSPC_ASSERT(a_stage_holds, aclk, aresetn, (valid_reg && !m_ready) |=> $stable(stage_reg), "stage counter moved while output stalled")

endmodule

`default_nettype wire

// ===== sv/video_stream_packet_classifier_unit.sv =====
// Streaming-video packet classifier, top level.
// Input channel (s_*): one payload byte per transaction with the packet's
// transport, length, a last mark and a flow-start mark. An empty packet is
// one transaction with s_last_byte set and its byte ignored.
// Output channel (m_*): one verdict transaction per packet, after the
// transaction that carries s_last_byte: 0 undecided, 1 detected, 2 excluded.
// Throughput: one input transaction per cycle while s_ready is high; the
// scanner updates its running match state once per accepted byte.
// After the last byte is accepted, the packet's record passes through the
// two-entry record queue into the output register, which holds its verdict.
// When the receiver stalls, the output register holds its verdict and the
// queue absorbs up to two more finished packets; s_ready drops only when
// the queue is full.
// Reset (aresetn, synchronous, active low) clears the packet state, the UDP
// stage counter, the queue and the output. Stored header bytes are not
// cleared; each packet must deliver the header bytes its verdict reads.
// Depends on vspc_pkg, vspc_front, vspc_queue and vspc_back.
`default_nettype none

module video_stream_packet_classifier_unit
    import vspc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_transport,
    input  wire logic [15:0] s_packet_length,
    input  wire logic [7:0]  s_payload_byte,
    input  wire logic        s_last_byte,
    input  wire logic        s_flow_start,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [1:0]       m_verdict
);

    logic push_valid, push_ready;
    rec_t push_data;
    logic pop_valid, pop_ready;
    rec_t pop_data;

    vspc_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_transport     (s_transport),
        .s_packet_length (s_packet_length),
        .s_payload_byte  (s_payload_byte),
        .s_last_byte     (s_last_byte),
        .s_flow_start    (s_flow_start),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    vspc_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    vspc_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_verdict (m_verdict)
    );

endmodule

`default_nettype wire
